// ----- rtl/lhal_pkg.sv -----
package lhal_pkg;

    // Action codes carried in the action field of an input beat
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [4:0]  letter_index;
        logic [15:0] item_id;
        logic [9:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic        winner_valid;
        logic [4:0]  winner_letter;
        logic [10:0] winner_count;
        logic        entry_valid;
        logic [15:0] entry_id;
        logic        overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_item;
        logic issue_read;
        logic commit_record;
        logic load_result;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_record;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/lhal_ram.sv -----
module lhal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lhal_ctrl.sv -----
module lhal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lhal_pkg::t_status i_status,
    output lhal_pkg::t_cmd    o_cmd
);

    lhal_pkg::t_state r_state;
    lhal_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            lhal_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = lhal_pkg::S_READ;
                end
            end
            lhal_pkg::S_READ: begin
                o_cmd.issue_read = 1'b1;
                n_state          = lhal_pkg::S_EXEC;
            end
            lhal_pkg::S_EXEC: begin
                if (i_status.is_record) begin
                    o_cmd.commit_record = 1'b1;
                    n_state             = lhal_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = lhal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lhal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != lhal_pkg::S_IDLE);

endmodule

// ----- rtl/lhal_dp.sv -----
module lhal_dp #(
    parameter int LETTERS      = 26,
    parameter int BUCKET_DEPTH = 1024,
    parameter int ID_WIDTH     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lhal_pkg::t_in_item  i_item,
    input  lhal_pkg::t_cmd      i_cmd,
    output lhal_pkg::t_status   o_status,
    output logic                o_valid,
    input  logic                i_stall,
    output lhal_pkg::t_out_item o_item
);

    localparam int LetW  = $clog2(LETTERS);
    localparam int CntW  = $clog2(BUCKET_DEPTH + 1);
    localparam int AddrW = $clog2(LETTERS * BUCKET_DEPTH);
    localparam logic [CntW-1:0] FullCnt = CntW'(BUCKET_DEPTH);

    lhal_pkg::t_in_item  r_item;
    lhal_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [LETTERS-1:0]  r_cnt_valid;
    logic                r_rd_cnt_valid;
    logic [LetW-1:0]     r_leader;
    logic [CntW-1:0]     r_leader_cnt;
    logic                r_overflow;

    logic                letter_ok;
    logic [LetW-1:0]     letter_addr;
    logic [CntW-1:0]     cnt_rdata;
    logic [CntW-1:0]     cur_cnt;
    logic [CntW-1:0]     new_cnt;
    logic                bucket_full;
    logic                do_store;
    logic                take_lead;
    logic [AddrW-1:0]    id_waddr;
    logic [AddrW-1:0]    id_raddr;
    logic [ID_WIDTH-1:0] id_rdata;
    logic                entry_ok;

    assign letter_ok   = (32'(r_item.letter_index) < LETTERS);
    assign letter_addr = letter_ok ? LetW'(r_item.letter_index) : '0;
    assign cur_cnt     = r_rd_cnt_valid ? cnt_rdata : '0;
    assign new_cnt     = cur_cnt + CntW'(1);
    assign bucket_full = (cur_cnt == FullCnt);
    assign do_store    = i_cmd.commit_record && letter_ok && !bucket_full;
    assign take_lead   = (new_cnt > r_leader_cnt) ||
                         ((new_cnt == r_leader_cnt) && (letter_addr < r_leader));

    assign entry_ok = (r_leader_cnt != '0) &&
                      (32'(r_item.entry_index) < 32'(r_leader_cnt));

    assign id_waddr = AddrW'(32'(letter_addr) * BUCKET_DEPTH + 32'(cur_cnt));
    assign id_raddr = AddrW'(32'(r_leader) * BUCKET_DEPTH +
                             (entry_ok ? 32'(r_item.entry_index) : 32'd0));

    lhal_ram #(
        .WIDTH (CntW),
        .DEPTH (LETTERS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (letter_addr),
        .i_wdata (new_cnt),
        .i_re    (i_cmd.issue_read),
        .i_raddr (letter_addr),
        .o_rdata (cnt_rdata)
    );

    lhal_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (LETTERS * BUCKET_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (id_waddr),
        .i_wdata (ID_WIDTH'(r_item.item_id)),
        .i_re    (i_cmd.issue_read),
        .i_raddr (id_raddr),
        .o_rdata (id_rdata)
    );

    // Item holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item <= i_item;
        end
    end

    // Count validity, leader and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid    <= '0;
            r_rd_cnt_valid <= 1'b0;
            r_leader       <= '0;
            r_leader_cnt   <= '0;
            r_overflow     <= 1'b0;
        end else begin
            if (i_cmd.issue_read) begin
                r_rd_cnt_valid <= r_cnt_valid[letter_addr];
            end
            if (do_store) begin
                r_cnt_valid[letter_addr] <= 1'b1;
                if (take_lead) begin
                    r_leader     <= letter_addr;
                    r_leader_cnt <= new_cnt;
                end
            end
            if (i_cmd.commit_record && letter_ok && bucket_full) begin
                r_overflow <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out.winner_valid  <= (r_leader_cnt != '0);
            r_out.winner_letter <= (r_leader_cnt != '0) ? 5'(r_leader) : '0;
            r_out.winner_count  <= 11'(r_leader_cnt);
            r_out.entry_valid   <= entry_ok;
            r_out.entry_id      <= entry_ok ? 16'(id_rdata) : '0;
            r_out.overflow      <= r_overflow;
        end
    end

    assign o_status.is_record = (r_item.action == lhal_pkg::ACT_RECORD);
    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_valid            = r_out_valid;
    assign o_item             = r_out;

endmodule

// ----- rtl/letter_histogram_argmax_lists_unit.sv -----
// Flow: an accepted beat is latched in the idle state, the count RAM and the id
// RAM are read in the read state, and the exec state commits a record or loads
// a report into the result register, holding while that register is full and
// stalled. A new input beat is taken only once the block is back in idle.
// Reset (i_rst_n low, synchronous) clears counts, leader, overflow flag and
// the result register; the id RAM is not cleared and needs no clearing pass.
module letter_histogram_argmax_lists_unit #(
    parameter int LETTERS      = 26,
    parameter int BUCKET_DEPTH = 1024,
    parameter int ID_WIDTH     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lhal_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output lhal_pkg::t_out_item o_item
);

    // Command and status between the sequencer and the datapath
    lhal_pkg::t_cmd    cmd;
    lhal_pkg::t_status status;

    // Sequencer: accept in idle, read the RAMs, then commit a record or
    // load a report into the result register (hold while it is still full)
    lhal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: bucket counts with per-letter valid bits, id lists in one
    // flat RAM addressed by letter and position, the leader tracked on each
    // record, and the result register that parts the output side
    lhal_dp #(
        .LETTERS      (LETTERS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .ID_WIDTH     (ID_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule

// ----- rtl/lhal_checker.sv -----
module lhal_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input lhal_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input lhal_pkg::t_out_item o_item
);

    // No result beat straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result beat changed");

    // One item at a time: an accepted beat closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted back to back");

    // A leader exists exactly when its count is nonzero
    a_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.winner_valid == (o_item.winner_count != 11'd0)))
        else $error("winner flag disagrees with count");

    // An invalid entry reads as zero and needs a leader to be valid
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.entry_valid ? o_item.winner_valid
                                        : (o_item.entry_id == 16'd0)))
        else $error("entry fields inconsistent");

endmodule

bind letter_histogram_argmax_lists_unit lhal_checker u_lhal_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Shape of the block under test, mirrored for the shadow model
    localparam int NUM_LETTERS = 26;
    localparam int LIST_DEPTH  = 1024;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    lhal_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    lhal_pkg::t_out_item o_item;

    letter_histogram_argmax_lists_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the histogram: per-letter tallies, id lists, leader, sticky overflow
    logic [10:0] tally [NUM_LETTERS];
    logic [15:0] id_lists [NUM_LETTERS][LIST_DEPTH];
    logic [4:0]  lead_letter;
    logic [10:0] lead_tally;
    logic        overflow_seen;

    lhal_pkg::t_in_item  pending_beats[$];     // beats waiting to be driven
    lhal_pkg::t_out_item expected_reports[$];  // report results still owed by the block

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int beats_taken    = 0;
    int records_taken  = 0;
    int reports_checked = 0;

    // Apply one accepted beat to the shadow histogram. Returns 1 and fills rep when
    // the beat is a report; records update state and return 0.
    function automatic bit histogram_step(input lhal_pkg::t_in_item beat,
                                          output lhal_pkg::t_out_item rep);
        logic [10:0] cnt;
        logic [4:0]  ltr;
        rep = '0;
        if (beat.action == lhal_pkg::ACT_RECORD) begin
            ltr = beat.letter_index;
            // letters beyond the alphabet are dropped without touching anything
            if (ltr < NUM_LETTERS) begin
                cnt = tally[ltr];
                if (cnt >= LIST_DEPTH) begin
                    // full list: keep the count at capacity, flag the loss
                    overflow_seen = 1'b1;
                end else begin
                    id_lists[ltr][cnt[9:0]] = beat.item_id;
                    cnt = cnt + 11'd1;
                    tally[ltr] = cnt;
                    // counts only rise, so the leader moves without a scan;
                    // equal counts favour the lower letter
                    if (cnt > lead_tally || (cnt == lead_tally && ltr < lead_letter)) begin
                        lead_tally  = cnt;
                        lead_letter = ltr;
                    end
                end
            end
            return 1'b0;
        end
        // report: all zero while no letter has been seen
        if (lead_tally != 11'd0) begin
            rep.winner_valid  = 1'b1;
            rep.winner_letter = lead_letter;
            rep.winner_count  = lead_tally;
            if (beat.entry_index < lead_tally) begin
                rep.entry_valid = 1'b1;
                rep.entry_id    = id_lists[lead_letter][beat.entry_index];
            end
        end
        rep.overflow = overflow_seen;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report(input lhal_pkg::t_out_item want,
                                  input lhal_pkg::t_out_item got);
        check_field("winner_valid",  16'(want.winner_valid),  16'(got.winner_valid));
        check_field("winner_letter", 16'(want.winner_letter), 16'(got.winner_letter));
        check_field("winner_count",  16'(want.winner_count),  16'(got.winner_count));
        check_field("entry_valid",   16'(want.entry_valid),   16'(got.entry_valid));
        check_field("entry_id",      want.entry_id,           got.entry_id);
        check_field("overflow",      16'(want.overflow),      16'(got.overflow));
    endtask

    // Driver: hold a stalled beat, otherwise retire the accepted one into the
    // shadow model and either present the next pending beat or idle.
    always @(posedge i_clk) begin
        lhal_pkg::t_out_item rep;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                beats_taken++;
                if (histogram_step(i_item, rep)) begin
                    expected_reports.push_back(rep);
                end else begin
                    records_taken++;
                end
            end
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_item  <= pending_beats.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result beat with the oldest owed report,
    // then choose whether to stall the next cycle.
    always @(posedge i_clk) begin
        lhal_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, o_item);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_report(want, o_item);
                    reports_checked++;
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic lhal_pkg::t_in_item rec(input logic [4:0] letter,
                                               input logic [15:0] id);
        lhal_pkg::t_in_item b;
        b.action       = lhal_pkg::ACT_RECORD;
        b.letter_index = letter;
        b.item_id      = id;
        b.entry_index  = 10'($urandom_range(0, 1023));  // ignored by a record
        return b;
    endfunction

    function automatic lhal_pkg::t_in_item rpt(input logic [9:0] entry);
        lhal_pkg::t_in_item b;
        b.action       = lhal_pkg::ACT_REPORT;
        b.letter_index = 5'($urandom_range(0, 31));     // ignored by a report
        b.item_id      = 16'($urandom_range(0, 16'hFFFF));
        b.entry_index  = entry;
        return b;
    endfunction

    // Random beat: letters lean on a few buckets so ties and leader swaps occur;
    // entry indices lean low so most reports land inside the leader's list.
    function automatic lhal_pkg::t_in_item random_beat();
        int          pick;
        logic [4:0]  letter;
        logic [9:0]  entry;
        pick = $urandom_range(0, 99);
        if (pick < 40)      letter = 5'($urandom_range(0, 3));
        else if (pick < 85) letter = 5'($urandom_range(0, NUM_LETTERS - 1));
        else                letter = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 50)      entry = 10'($urandom_range(0, 15));
        else if (pick < 80) entry = 10'($urandom_range(0, 127));
        else                entry = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 30) return rpt(entry);
        return rec(letter, 16'($urandom_range(0, 16'hFFFF)));
    endfunction

    task automatic queue_random(input int count);
        repeat (count) pending_beats.push_back(random_beat());
    endtask

    // Sample on the falling edge so the driver's updates have settled
    task automatic drain();
        while (pending_beats.size() != 0 || i_valid || expected_reports.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        for (int l = 0; l < NUM_LETTERS; l++) tally[l] = '0;
        lead_letter   = '0;
        lead_tally    = '0;
        overflow_seen = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty histogram, ignored letters, tie-breaking, list edges
        pending_beats.push_back(rpt(10'd0));           // no leader yet
        pending_beats.push_back(rpt(10'd1023));
        pending_beats.push_back(rec(5'd31, 16'hFFFF)); // letter past the alphabet
        pending_beats.push_back(rec(5'd26, 16'h1234));
        pending_beats.push_back(rpt(10'd0));
        pending_beats.push_back(rec(5'd0, 16'h0000));
        pending_beats.push_back(rpt(10'd0));
        pending_beats.push_back(rpt(10'd1));           // just past the list end
        pending_beats.push_back(rec(5'd1, 16'hFFFF));
        pending_beats.push_back(rpt(10'd0));           // tie goes to the lower letter
        pending_beats.push_back(rec(5'd1, 16'h8001));
        pending_beats.push_back(rpt(10'd1));           // leader moves up
        pending_beats.push_back(rec(5'd0, 16'hAAAA));
        pending_beats.push_back(rpt(10'd1));           // tie again, back to the lower letter
        pending_beats.push_back(rec(5'd25, 16'h5555));
        pending_beats.push_back(rec(5'd25, 16'h0001));
        pending_beats.push_back(rec(5'd25, 16'h7FFF));
        pending_beats.push_back(rpt(10'd2));
        pending_beats.push_back(rpt(10'd3));
        pending_beats.push_back(rpt(10'd1023));
        drain();

        // Random mixes under each idling pattern
        queue_random(100);
        drain();
        send_idle_pct  = 83;
        queue_random(100);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        queue_random(100);
        drain();
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        queue_random(100);
        drain();

        // Grow the last letter into the lead, peeking at the list as it grows
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 100; k++) begin
            pending_beats.push_back(rec(5'd25, 16'($urandom_range(0, 16'hFFFF))));
            if (k % 20 == 19) pending_beats.push_back(rpt(10'($urandom_range(0, 127))));
        end
        pending_beats.push_back(rpt(10'd1023));
        pending_beats.push_back(rpt(10'd0));
        drain();

        // A last random stretch with the long bucket in charge
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        queue_random(40);
        drain();

        // allow any stray late beat to surface
        repeat (8) @(posedge i_clk);

        $display("Covered %0d input beats (%0d records), %0d reports compared, %0d mismatches",
                 beats_taken, records_taken, reports_checked, fail_count);
        $display("Included empty and tied leaders, ignored letters and one long bucket list");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legitimate run
    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
